### hdl/rv32i_pkg.sv
// rv32i step core: shared types, opcodes and status codes
// no dependencies; imported by all rv32i modules
package rv32i_pkg;

  localparam logic [6:0] OP_LUI    = 7'h37;
  localparam logic [6:0] OP_AUIPC  = 7'h17;
  localparam logic [6:0] OP_JAL    = 7'h6F;
  localparam logic [6:0] OP_JALR   = 7'h67;
  localparam logic [6:0] OP_BRANCH = 7'h63;
  localparam logic [6:0] OP_LOAD   = 7'h03;
  localparam logic [6:0] OP_STORE  = 7'h23;
  localparam logic [6:0] OP_IMM    = 7'h13;
  localparam logic [6:0] OP_REG    = 7'h33;
  localparam logic [6:0] OP_FENCE  = 7'h0F;
  localparam logic [6:0] OP_SYSTEM = 7'h73;

  localparam logic [6:0] F7_ALT = 7'h20;
  localparam logic [31:0] MASK_B = 32'h0000_00FF;
  localparam logic [31:0] MASK_H = 32'h0000_FFFF;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_ILLEGAL = 3'd1,
    ST_UNIMPL  = 3'd2,
    ST_RANGE   = 3'd3,
    ST_MISALGN = 3'd4
  } status_e;

  // request passed from front to back through the queue
  typedef struct packed {
    logic        cmd;
    logic [11:0] word_addr;
    logic [31:0] word_data;
  } req_t;

endpackage

### hdl/rv32i_instruction_step.sv
// rv32i step core top level: front queue plus execution back end
// depends on rv32i_pkg, rv32i_front, rv32i_back
//
// Usage: one item per input request. cmd 0 writes word_data into memory
// word word_addr; cmd 1 executes the instruction at the program counter.
// Every request yields exactly one result on the output channel with the
// new pc, a status and the destination register write.
// Path: from request accept to result valid, a memory write passes the
// queue and the write; an execute passes the queue, fetch, execute and
// result, with a memory step added for a load or store, since each access
// uses the single synchronous memory port once.
// Flow: with the receiver ready, the back end takes a new request only
// once it is through with the last one, as set by the memory port and the
// sequencer; a two-entry front queue keeps taking requests meanwhile.
// Reset clears pc, registers and queue; memory content is undefined until
// written. If the receiver stalls, the result holds and the back end waits;
// the queue fills and then in_ready_o drops.
module rv32i_instruction_step
  import rv32i_pkg::*;
#(
  parameter int unsigned MEM_WORDS = 4096
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        cmd_i,
  input  logic [11:0] word_addr_i,
  input  logic [31:0] word_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] pc_after_o,
  output logic [2:0]  status_o,
  output logic        reg_written_o,
  output logic [4:0]  reg_index_o,
  output logic [31:0] reg_value_o
);

  req_t in_req, q_req;
  logic q_valid, q_ready;

  assign in_req = '{cmd: cmd_i, word_addr: word_addr_i, word_data: word_data_i};

  rv32i_front u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o,
    .in_req_i(in_req), .req_valid_o(q_valid), .req_ready_i(q_ready), .req_o(q_req)
  );

  rv32i_back #(.MemWords(MEM_WORDS)) u_back (
    .clk_i, .rst_ni, .req_valid_i(q_valid), .req_ready_o(q_ready), .req_i(q_req),
    .out_valid_o, .out_ready_i, .pc_after_o, .status_o, .reg_written_o,
    .reg_index_o, .reg_value_o
  );

endmodule

### hdl/rv32i_front.sv
// rv32i step core: input front end, two-entry request queue
// depends on rv32i_pkg
module rv32i_front
  import rv32i_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  req_t        in_req_i,
  output logic        req_valid_o,
  input  logic        req_ready_i,
  output req_t        req_o
);

  req_t       buf_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;
  logic       push, pop;

  assign in_ready_o  = (cnt_q != 2'd2);
  assign req_valid_o = (cnt_q != 2'd0);
  assign req_o       = buf_q[rd_ptr_q];
  assign push        = in_valid_i && in_ready_o;
  assign pop         = req_valid_o && req_ready_i;

  // queue payload
  always_ff @(posedge clk_i) begin
    if (push) buf_q[wr_ptr_q] <= in_req_i;
  end

  // queue pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (pop)  rd_ptr_q <= ~rd_ptr_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

### hdl/rv32i_back.sv
// rv32i step core: execution back end with memory, register file and pc
// depends on rv32i_pkg
module rv32i_back
  import rv32i_pkg::*;
#(
  parameter int unsigned MemWords = 4096
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        req_valid_i,
  output logic        req_ready_o,
  input  req_t        req_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] pc_after_o,
  output logic [2:0]  status_o,
  output logic        reg_written_o,
  output logic [4:0]  reg_index_o,
  output logic [31:0] reg_value_o
);

  localparam int unsigned AW = $clog2(MemWords);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_FETCH = 5'b00010,
    S_EXEC  = 5'b00100,
    S_MEM   = 5'b01000,
    S_DONE  = 5'b10000
  } state_e;

  state_e      state_q, state_d;
  logic [31:0] mem [MemWords];
  logic [31:0] rf_q [32];
  logic [31:0] pc_q;
  logic [31:0] rdata_q;
  logic [31:0] ir_q;
  logic        out_valid_q;
  logic [31:0] o_pc_q;
  logic [2:0]  o_st_q;
  logic        o_wr_q;
  logic [4:0]  o_idx_q;
  logic [31:0] o_val_q;

  // memory port control
  logic          mem_we;
  logic [AW-1:0] mem_addr;
  logic [31:0]   mem_wdata;

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_addr] <= mem_wdata;
    rdata_q <= mem[mem_addr];
  end

  // decode of latched instruction
  logic [31:0] w, a, b, immi, imms, immb, immj, seq, sum_ai, sum_as;
  logic [6:0]  op, f7;
  logic [4:0]  rd;
  logic [2:0]  f3;
  assign w    = ir_q;
  assign op   = w[6:0];
  assign rd   = w[11:7];
  assign f3   = w[14:12];
  assign f7   = w[31:25];
  assign a    = rf_q[w[19:15]];
  assign b    = rf_q[w[24:20]];
  assign immi = {{20{w[31]}}, w[31:20]};
  assign imms = {{20{w[31]}}, w[31:25], w[11:7]};
  assign immb = {{19{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
  assign immj = {{11{w[31]}}, w[31], w[19:12], w[20], w[30:21], 1'b0};
  assign seq  = pc_q + 32'd4;
  assign sum_ai = a + immi;
  assign sum_as = a + imms;

  // execute: result for all but the memory access
  logic [2:0]  ex_st;
  logic        ex_rd, ex_mem, take;
  logic [31:0] ex_npc, ex_val, tgt, ob, maddr;
  logic [4:0]  shamt;
  always_comb begin
    ex_st  = ST_OK;
    ex_rd  = 1'b0;
    ex_mem = 1'b0;
    ex_npc = seq;
    ex_val = 32'd0;
    take   = 1'b0;
    tgt    = 32'd0;
    ob     = b;
    shamt  = 5'd0;
    maddr  = (op == OP_STORE) ? sum_as : sum_ai;
    if (w != 32'd0) begin
      case (op)
        OP_LUI: begin
          ex_val = {w[31:12], 12'd0}; ex_rd = 1'b1;
        end
        OP_AUIPC: begin
          ex_val = pc_q + {w[31:12], 12'd0}; ex_rd = 1'b1;
        end
        OP_JAL: begin
          tgt = pc_q + immj;
          if (tgt[1]) ex_st = ST_MISALGN;
          else begin ex_npc = tgt; ex_val = seq; ex_rd = 1'b1; end
        end
        OP_JALR: begin
          tgt = {sum_ai[31:1], 1'b0};
          if (f3 != 3'd0) ex_st = ST_ILLEGAL;
          else if (tgt[1]) ex_st = ST_MISALGN;
          else begin ex_npc = tgt; ex_val = seq; ex_rd = 1'b1; end
        end
        OP_BRANCH: begin
          case (f3)
            3'd0: take = (a == b);
            3'd1: take = (a != b);
            3'd4: take = ($signed(a) < $signed(b));
            3'd5: take = !($signed(a) < $signed(b));
            3'd6: take = (a < b);
            3'd7: take = (a >= b);
            default: ex_st = ST_ILLEGAL;
          endcase
          tgt = pc_q + immb;
          if (ex_st == ST_OK && take) begin
            if (tgt[1]) ex_st = ST_MISALGN;
            else ex_npc = tgt;
          end
        end
        OP_LOAD, OP_STORE: begin
          if ((op == OP_LOAD && (f3 == 3'd3 || f3 > 3'd5)) ||
              (op == OP_STORE && f3 > 3'd2)) ex_st = ST_ILLEGAL;
          else if ((f3[1:0] == 2'd1 && maddr[0]) ||
                   (f3[1:0] == 2'd2 && maddr[1:0] != 2'd0)) ex_st = ST_MISALGN;
          else if ((maddr >> 2) >= 32'(MemWords)) ex_st = ST_RANGE;
          else ex_mem = 1'b1;
        end
        OP_IMM, OP_REG: begin
          if (op == OP_REG) begin
            if (f7 == F7_ALT) begin
              if (f3 != 3'd0 && f3 != 3'd5) ex_st = ST_ILLEGAL;
            end else if (f7 != 7'd0) ex_st = ST_ILLEGAL;
          end else begin
            if (f3 == 3'd1 && f7 != 7'd0) ex_st = ST_ILLEGAL;
            if (f3 == 3'd5 && f7 != 7'd0 && f7 != F7_ALT) ex_st = ST_ILLEGAL;
            ob = immi;
          end
          shamt = ob[4:0];
          case (f3)
            3'd0: ex_val = (op == OP_REG && f7 == F7_ALT) ? a - ob : a + ob;
            3'd1: ex_val = a << shamt;
            3'd2: ex_val = {31'd0, $signed(a) < $signed(ob)};
            3'd3: ex_val = {31'd0, a < ob};
            3'd4: ex_val = a ^ ob;
            3'd5: ex_val = (f7 == F7_ALT) ? 32'($signed(a) >>> shamt) : a >> shamt;
            3'd6: ex_val = a | ob;
            default: ex_val = a & ob;
          endcase
          ex_rd = (ex_st == ST_OK);
        end
        OP_FENCE: ex_st = (f3 <= 3'd1) ? ST_UNIMPL : ST_ILLEGAL;
        OP_SYSTEM: ex_st = ST_UNIMPL;
        default: ex_st = ST_ILLEGAL;
      endcase
    end
  end

  // memory access register stage
  logic [31:0] ma_q;
  logic [4:0]  sh;
  logic [31:0] ld_raw, ld_val, st_mask, st_word;
  assign sh     = {ma_q[1:0], 3'd0};
  assign ld_raw = rdata_q >> sh;
  always_comb begin
    case (f3)
      3'd0: ld_val = {{24{ld_raw[7]}}, ld_raw[7:0]};
      3'd1: ld_val = {{16{ld_raw[15]}}, ld_raw[15:0]};
      3'd4: ld_val = ld_raw & MASK_B;
      3'd5: ld_val = ld_raw & MASK_H;
      default: ld_val = ld_raw;
    endcase
    case (f3)
      3'd0: st_mask = MASK_B << sh;
      3'd1: st_mask = MASK_H << sh;
      default: st_mask = 32'hFFFF_FFFF;
    endcase
    st_word = (rdata_q & ~st_mask) | ((b << sh) & st_mask);
  end

  logic fetch_bad;
  assign fetch_bad = (pc_q[1:0] != 2'd0) || ((pc_q >> 2) >= 32'(MemWords));

  // handshake: a new request may enter while the held result leaves
  assign req_ready_o = (state_q == S_IDLE) && (!out_valid_q || out_ready_i);

  always_comb begin
    mem_we    = 1'b0;
    mem_addr  = pc_q[AW+1:2];
    mem_wdata = req_i.word_data;
    state_d   = state_q;
    case (state_q)
      S_IDLE: begin
        if (req_valid_i && req_ready_o) begin
          if (!req_i.cmd) begin
            mem_addr = AW'(req_i.word_addr);
            mem_we   = (32'(req_i.word_addr) < 32'(MemWords));
            state_d  = S_DONE;
          end else if (fetch_bad) state_d = S_DONE;
          else state_d = S_FETCH;
        end
      end
      S_FETCH: state_d = S_EXEC;
      S_EXEC: begin
        mem_addr = maddr[AW+1:2];
        state_d  = (ex_mem && ex_st == ST_OK) ? S_MEM : S_DONE;
      end
      S_MEM: begin
        mem_addr  = ma_q[AW+1:2];
        mem_wdata = st_word;
        mem_we    = (op == OP_STORE);
        state_d   = S_DONE;
      end
      S_DONE: state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // sequencer, architectural state and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      pc_q        <= 32'd0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < 32; i++) rf_q[i] <= 32'd0;
    end else begin
      state_q <= state_d;
      if (out_valid_q && out_ready_i) out_valid_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (req_valid_i && req_ready_o) begin
            o_pc_q <= pc_q; o_wr_q <= 1'b0; o_idx_q <= 5'd0; o_val_q <= 32'd0;
            if (!req_i.cmd)
              o_st_q <= (32'(req_i.word_addr) < 32'(MemWords)) ? ST_OK : ST_RANGE;
            else
              o_st_q <= pc_q[1:0] != 2'd0 ? ST_MISALGN : ST_RANGE;
          end
        end
        S_FETCH: ir_q <= rdata_q;
        S_EXEC: begin
          ma_q   <= maddr;
          o_st_q <= ex_st;
          if (ex_st == ST_OK && !ex_mem) begin
            pc_q   <= ex_npc;
            o_pc_q <= ex_npc;
            if (ex_rd) begin
              o_idx_q <= rd; o_val_q <= ex_val; o_wr_q <= (rd != 5'd0);
              if (rd != 5'd0) rf_q[rd] <= ex_val;
            end
          end
        end
        S_MEM: begin
          pc_q   <= seq;
          o_pc_q <= seq;
          if (op == OP_LOAD) begin
            o_idx_q <= rd; o_val_q <= ld_val; o_wr_q <= (rd != 5'd0);
            if (rd != 5'd0) rf_q[rd] <= ld_val;
          end
        end
        S_DONE: out_valid_q <= 1'b1;
        default: ;
      endcase
    end
  end

  assign out_valid_o   = out_valid_q;
  assign pc_after_o    = o_pc_q;
  assign status_o      = o_st_q;
  assign reg_written_o = o_wr_q;
  assign reg_index_o   = o_idx_q;
  assign reg_value_o   = o_val_q;

endmodule

### hdl/rv32i_checker.sv
// rv32i step core: port-level checker and bind
// depends on rv32i_pkg
module rv32i_checker
  import rv32i_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [31:0] pc_after_o,
  input logic [2:0]  status_o,
  input logic        reg_written_o,
  input logic [4:0]  reg_index_o,
  input logic [31:0] reg_value_o
);

  // result holds while stalled
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(pc_after_o))
    else $error("result dropped under stall");

  // status in range
  a_stat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> status_o <= ST_MISALGN) else $error("bad status");

  // register write only on ok status to a nonzero index
  a_wr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && reg_written_o |-> status_o == ST_OK && reg_index_o != 5'd0)
    else $error("bad register write");

  // failing items report no register fields
  a_clr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != ST_OK |-> reg_index_o == 5'd0 && reg_value_o == 32'd0)
    else $error("stale register fields");

endmodule

bind rv32i_instruction_step rv32i_checker u_checker (
  .clk_i, .rst_ni, .out_valid_o, .out_ready_i, .pc_after_o, .status_o,
  .reg_written_o, .reg_index_o, .reg_value_o
);

### tb/tb_top.sv
// testbench for rv32i_instruction_step: directed table, then random programs
// checked against an in-bench architectural predictor; needs rv32i_pkg and the rtl
module tb_top;
  import rv32i_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NUM_WORDS = 4096;
  localparam int unsigned TOTAL_ITEMS = 1100;
  localparam int unsigned IDLE_LIMIT = 2000;

  typedef struct packed {
    logic [31:0] pc;
    logic [2:0]  st;
    logic        wr;
    logic [4:0]  idx;
    logic [31:0] val;
  } step_res_t;

  typedef struct packed {
    logic        cmd;
    logic [11:0] addr;
    logic [31:0] data;
    logic        fixed;
    logic [31:0] pc;
    logic [2:0]  st;
  } dir_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic        cmd_i = 1'b0;
  logic [11:0] word_addr_i = '0;
  logic [31:0] word_data_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [31:0] pc_after_o;
  logic [2:0]  status_o;
  logic        reg_written_o;
  logic [4:0]  reg_index_o;
  logic [31:0] reg_value_o;

  rv32i_instruction_step u_top (.*);

  always #1 clk_i = ~clk_i;

  // predicted architectural state
  logic [31:0] arch_pc;
  logic [31:0] arch_regs [32];
  logic [31:0] arch_mem [NUM_WORDS];
  bit          mem_valid [NUM_WORDS];
  step_res_t   pending_q [$];
  int          errors = 0;
  int          burst_left = 0;
  int          items_sent = 0;

  // one instruction: status plus the effects it would have
  function automatic status_e exec_one(output logic [31:0] npc, output bit has_rd,
                                       output logic [4:0] rd, output logic [31:0] val,
                                       output int dword, output bit do_st,
                                       output logic [31:0] smask, output logic [31:0] sdata);
    logic [31:0] w, a, b, immi, tgt, addr, v, mask;
    logic [6:0] op, f7;
    logic [2:0] f3;
    bit take;
    has_rd = 0; do_st = 0; dword = -1; val = '0; smask = '0; sdata = '0;
    npc = arch_pc; rd = '0;
    if (arch_pc[1:0] != 2'd0) return ST_MISALGN;
    if ((arch_pc >> 2) >= NUM_WORDS) return ST_RANGE;
    w = arch_mem[arch_pc >> 2];
    op = w[6:0]; rd = w[11:7]; f3 = w[14:12]; f7 = w[31:25];
    a = arch_regs[w[19:15]];
    b = arch_regs[w[24:20]];
    immi = {{20{w[31]}}, w[31:20]};
    npc = arch_pc + 32'd4;
    if (w == '0) return ST_OK;
    case (op)
      OP_LUI: val = {w[31:12], 12'd0};
      OP_AUIPC: val = arch_pc + {w[31:12], 12'd0};
      OP_JAL: begin
        tgt = arch_pc + {{11{w[31]}}, w[31], w[19:12], w[20], w[30:21], 1'b0};
        if (tgt[1:0] != 2'd0) return ST_MISALGN;
        val = npc; npc = tgt;
      end
      OP_JALR: begin
        if (f3 != 3'd0) return ST_ILLEGAL;
        tgt = (a + immi) & ~32'd1;
        if (tgt[1:0] != 2'd0) return ST_MISALGN;
        val = npc; npc = tgt;
      end
      OP_BRANCH: begin
        case (f3)
          3'd0: take = (a == b);
          3'd1: take = (a != b);
          3'd4: take = ($signed(a) < $signed(b));
          3'd5: take = ($signed(a) >= $signed(b));
          3'd6: take = (a < b);
          3'd7: take = (a >= b);
          default: return ST_ILLEGAL;
        endcase
        if (take) begin
          tgt = arch_pc + {{19{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
          if (tgt[1:0] != 2'd0) return ST_MISALGN;
          npc = tgt;
        end
        return ST_OK;
      end
      OP_LOAD: begin
        if (f3 == 3'd3 || f3 > 3'd5) return ST_ILLEGAL;
        addr = a + immi;
        if ((f3[1:0] == 2'd1 && addr[0]) || (f3[1:0] == 2'd2 && addr[1:0] != 2'd0))
          return ST_MISALGN;
        if ((addr >> 2) >= NUM_WORDS) return ST_RANGE;
        dword = int'(addr >> 2);
        v = arch_mem[addr >> 2] >> (addr[1:0] * 8);
        case (f3)
          3'd0: v = {{24{v[7]}}, v[7:0]};
          3'd1: v = {{16{v[15]}}, v[15:0]};
          3'd4: v = v & MASK_B;
          3'd5: v = v & MASK_H;
          default: ;
        endcase
        val = v;
      end
      OP_STORE: begin
        if (f3 > 3'd2) return ST_ILLEGAL;
        addr = a + {{20{w[31]}}, w[31:25], w[11:7]};
        if ((f3 == 3'd1 && addr[0]) || (f3 == 3'd2 && addr[1:0] != 2'd0)) return ST_MISALGN;
        if ((addr >> 2) >= NUM_WORDS) return ST_RANGE;
        dword = int'(addr >> 2);
        mask = (f3 == 3'd0) ? MASK_B : (f3 == 3'd1) ? MASK_H : 32'hFFFF_FFFF;
        smask = mask << (addr[1:0] * 8);
        sdata = b << (addr[1:0] * 8);
        do_st = 1;
        return ST_OK;
      end
      OP_IMM, OP_REG: begin
        if (op == OP_REG) begin
          if (f7 == F7_ALT) begin
            if (f3 != 3'd0 && f3 != 3'd5) return ST_ILLEGAL;
          end else if (f7 != 7'd0) begin
            return ST_ILLEGAL;
          end
        end else begin
          if (f3 == 3'd1 && f7 != 7'd0) return ST_ILLEGAL;
          if (f3 == 3'd5 && f7 != 7'd0 && f7 != F7_ALT) return ST_ILLEGAL;
          b = immi;
        end
        case (f3)
          3'd0: v = (op == OP_REG && f7 == F7_ALT) ? a - b : a + b;
          3'd1: v = a << b[4:0];
          3'd2: v = {31'd0, $signed(a) < $signed(b)};
          3'd3: v = {31'd0, a < b};
          3'd4: v = a ^ b;
          3'd5: v = (f7 == F7_ALT) ? 32'($signed(a) >>> b[4:0]) : a >> b[4:0];
          3'd6: v = a | b;
          default: v = a & b;
        endcase
        val = v;
      end
      OP_FENCE: return (f3 <= 3'd1) ? ST_UNIMPL : ST_ILLEGAL;
      OP_SYSTEM: return ST_UNIMPL;
      default: return ST_ILLEGAL;
    endcase
    has_rd = 1;
    return ST_OK;
  endfunction

  // predicted result of one request; state is updated only when commit is set
  function automatic step_res_t predict_step(bit commit, logic cmd, logic [11:0] wa,
                                             logic [31:0] wd, output int dword);
    step_res_t r;
    status_e st;
    logic [31:0] npc, val, smask, sdata;
    logic [4:0] rd;
    bit has_rd, do_st;
    r = '0;
    dword = -1;
    if (!cmd) begin
      if (commit) begin
        arch_mem[wa] = wd;
        mem_valid[wa] = 1;
      end
      r.pc = arch_pc;
      r.st = ST_OK;
      return r;
    end
    st = exec_one(npc, has_rd, rd, val, dword, do_st, smask, sdata);
    r.pc = arch_pc;
    r.st = st;
    if (st == ST_OK) begin
      r.pc = npc;
      if (has_rd) begin
        r.wr = (rd != 5'd0);
        r.idx = rd;
        r.val = val;
      end
      if (commit) begin
        arch_pc = npc;
        if (has_rd && rd != 5'd0) arch_regs[rd] = val;
        if (do_st) arch_mem[dword] = (arch_mem[dword] & ~smask) | (sdata & smask);
      end
    end
    return r;
  endfunction

  // drive one request in bursts with random gaps, predict on acceptance
  task automatic send_req(logic cmd, logic [11:0] wa, logic [31:0] wd,
                          logic fixed = 1'b0, logic [31:0] fpc = '0, logic [2:0] fst = '0);
    step_res_t r;
    int dw;
    if (burst_left == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 12);
    end
    burst_left--;
    in_valid_i <= 1'b1;
    cmd_i <= cmd;
    word_addr_i <= wa;
    word_data_i <= wd;
    do @(posedge clk_i); while (!in_ready_o);
    items_sent++;
    r = predict_step(1, cmd, wa, wd, dw);
    if (fixed) r = '{pc: fpc, st: fst, wr: 1'b0, idx: '0, val: '0};
    pending_q.push_back(r);
  endtask

  // random instruction, mostly well formed
  function automatic logic [31:0] rand_instr();
    logic [4:0] rd, rs1, rs2;
    logic [2:0] f3;
    logic [6:0] f7;
    logic [20:0] oj;
    logic [12:0] ob;
    logic [11:0] imm;
    rd = $urandom; rs1 = $urandom; rs2 = $urandom; f3 = $urandom; imm = $urandom;
    oj = 21'($urandom_range(0, 255) * 2) - 21'd256;
    ob = 13'($urandom_range(0, 255) * 2) - 13'd256;
    case ($urandom_range(0, 19))
      0: return {20'($urandom), rd, OP_LUI};
      1: return {20'($urandom), rd, OP_AUIPC};
      2: return {oj[20], oj[10:1], oj[11], oj[19:12], rd, OP_JAL};
      3: return {imm, ($urandom_range(0, 1) ? 5'd0 : rs1),
                 ($urandom_range(0, 9) == 0 ? f3 : 3'd0), rd, OP_JALR};
      4, 5: return {ob[12], ob[10:5], rs2, rs1, f3, ob[4:1], ob[11], OP_BRANCH};
      6, 7: return {imm, ($urandom_range(0, 1) ? 5'd0 : rs1), f3, rd, OP_LOAD};
      8, 9: return {imm[11:5], rs2, ($urandom_range(0, 1) ? 5'd0 : rs1), f3, imm[4:0], OP_STORE};
      10, 11, 12, 13: begin
        f7 = ($urandom_range(0, 3) == 0) ? 7'($urandom) : ($urandom_range(0, 1) ? F7_ALT : 7'd0);
        if (f3 == 3'd1 || f3 == 3'd5) return {f7, imm[4:0], rs1, f3, rd, OP_IMM};
        return {imm, rs1, f3, rd, OP_IMM};
      end
      14, 15, 16: begin
        f7 = ($urandom_range(0, 5) == 0) ? 7'($urandom) : ($urandom_range(0, 1) ? F7_ALT : 7'd0);
        return {f7, rs2, rs1, f3, rd, OP_REG};
      end
      17: return {$urandom_range(0, 1) ? OP_FENCE : OP_SYSTEM} | ($urandom & 32'hFFFF_FF80);
      18: return 32'd0;
      default: return $urandom;
    endcase
  endfunction

  // patch memory so that the next step fetches and touches only written words
  task automatic issue_step();
    step_res_t r;
    int dw;
    bit ready;
    ready = 0;
    while (!ready) begin
      if (!mem_valid[arch_pc >> 2]) begin
        send_req(1'b0, 12'(arch_pc >> 2), rand_instr());
      end else begin
        r = predict_step(0, 1'b1, '0, '0, dw);
        if (dw >= 0 && !mem_valid[dw]) begin
          send_req(1'b0, 12'(dw), $urandom);
        end else if (r.pc >= NUM_WORDS * 4 || (r.st != ST_OK && $urandom_range(0, 1) == 1)
                     || $urandom_range(0, 9) == 0) begin
          send_req(1'b0, 12'(arch_pc >> 2), rand_instr());
        end else begin
          ready = 1;
        end
      end
    end
    send_req(1'b1, 12'($urandom), $urandom);
  endtask

  // directed rows: short program, then error codes on a patched word
  dir_row_t dir_tbl [22] = '{
    '{1'b0, 12'd0,    32'h8000_00B7, 1'b1, 32'd0,  ST_OK},
    '{1'b0, 12'd1,    32'hFFF0_0113, 1'b1, 32'd0,  ST_OK},
    '{1'b0, 12'd2,    32'h0000_1197, 1'b1, 32'd0,  ST_OK},
    '{1'b0, 12'd3,    32'h0000_0000, 1'b1, 32'd0,  ST_OK},
    '{1'b0, 12'd4,    32'h41F0_D213, 1'b1, 32'd0,  ST_OK},
    '{1'b0, 12'd5,    32'h4020_02B3, 1'b1, 32'd0,  ST_OK},
    '{1'b0, 12'd6,    32'h0000_000F, 1'b1, 32'd0,  ST_OK},
    '{1'b0, 12'd4095, 32'hFFFF_FFFF, 1'b1, 32'd0,  ST_OK},
    '{1'b1, 12'd0,    32'd0,         1'b0, 32'd0,  ST_OK},
    '{1'b1, 12'hFFF,  32'hFFFF_FFFF, 1'b0, 32'd0,  ST_OK},
    '{1'b1, 12'd0,    32'd0,         1'b0, 32'd0,  ST_OK},
    '{1'b1, 12'd0,    32'd0,         1'b0, 32'd0,  ST_OK},
    '{1'b1, 12'd0,    32'd0,         1'b0, 32'd0,  ST_OK},
    '{1'b1, 12'd0,    32'd0,         1'b0, 32'd0,  ST_OK},
    '{1'b1, 12'd0,    32'd0,         1'b1, 32'd24, ST_UNIMPL},
    '{1'b0, 12'd6,    32'h0000_0073, 1'b1, 32'd24, ST_OK},
    '{1'b1, 12'd0,    32'd0,         1'b1, 32'd24, ST_UNIMPL},
    '{1'b0, 12'd6,    32'hFFFF_FFFF, 1'b1, 32'd24, ST_OK},
    '{1'b1, 12'd0,    32'd0,         1'b1, 32'd24, ST_ILLEGAL},
    '{1'b0, 12'd6,    32'h0410_2303, 1'b1, 32'd24, ST_OK},
    '{1'b1, 12'd0,    32'd0,         1'b1, 32'd24, ST_MISALGN},
    '{1'b0, 12'd6,    32'h0020_A023, 1'b1, 32'd24, ST_OK}
  };

  // stimulus
  initial begin
    arch_pc = '0;
    foreach (arch_regs[i]) arch_regs[i] = '0;
    foreach (mem_valid[i]) mem_valid[i] = 0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (dir_tbl[i])
      send_req(dir_tbl[i].cmd, dir_tbl[i].addr, dir_tbl[i].data, dir_tbl[i].fixed,
               dir_tbl[i].pc, dir_tbl[i].st);
    // out-of-range store left at pc 24
    send_req(1'b1, '0, '0, 1'b1, 32'd24, ST_RANGE);
    while (items_sent < TOTAL_ITEMS) begin
      if ($urandom_range(0, 19) == 0) send_req(1'b0, 12'($urandom), $urandom);
      else issue_step();
    end
    // jump home, then leave memory so the fetch goes out of range
    send_req(1'b0, 12'(arch_pc >> 2), 32'h0000_0067);
    send_req(1'b1, '0, '0);
    send_req(1'b0, 12'd0, 32'h1000_03B7);
    send_req(1'b0, 12'd1, 32'h0003_8067);
    repeat (4) send_req(1'b1, '0, '0);
    in_valid_i <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (errors == 0) $display("rv32i_instruction_step: match");
    else $display("rv32i_instruction_step: mismatch");
    $finish;
  end

  task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
    $display("error: %s got %h expected %h", field, got, want);
    errors++;
  endtask

  // receiver: clean stretches, hard stalls and choppy ready
  int rx_left = 0;
  int rx_mode = 0;
  always @(posedge clk_i) begin
    if (rx_left == 0) begin
      rx_mode = $urandom_range(0, 2);
      rx_left = (rx_mode == 0) ? $urandom_range(5, 40) : $urandom_range(1, 10);
    end
    rx_left--;
    out_ready_i <= (rx_mode == 0) ? 1'b1 : (rx_mode == 1) ? 1'b0 : 1'($urandom);
  end

  // result checker
  always @(posedge clk_i) begin
    step_res_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_q.size() == 0) begin
        report_mismatch("unexpected result pc", pc_after_o, '0);
      end else begin
        want = pending_q.pop_front();
        if (pc_after_o !== want.pc) report_mismatch("pc_after", pc_after_o, want.pc);
        if (status_o !== want.st) report_mismatch("status", 32'(status_o), 32'(want.st));
        if (reg_written_o !== want.wr)
          report_mismatch("reg_written", 32'(reg_written_o), 32'(want.wr));
        if (reg_index_o !== want.idx)
          report_mismatch("reg_index", 32'(reg_index_o), 32'(want.idx));
        if (reg_value_o !== want.val) report_mismatch("reg_value", reg_value_o, want.val);
      end
    end
  end

  // watchdog on cycles with no request or result moving
  int idle_cycles = 0;
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("rv32i_instruction_step: mismatch");
      $finish;
    end
  end

endmodule

### filelist.f
hdl/rv32i_pkg.sv
hdl/rv32i_front.sv
hdl/rv32i_back.sv
hdl/rv32i_instruction_step.sv
hdl/rv32i_checker.sv
tb/tb_top.sv
